>>> hdl/hkc_pkg.sv
`timescale 1ns / 1ps

package hkc_pkg;

   localparam int DISP_WIDTH = 32;

   localparam logic [7:0] KEY_BS     = 8'd8;
   localparam logic [7:0] KEY_CR     = 8'd13;
   localparam logic [7:0] KEY_ESCAPE = 8'd27;
   localparam logic [7:0] KEY_0      = 8'h30;
   localparam logic [7:0] KEY_9      = 8'h39;
   localparam logic [7:0] KEY_UP_A   = 8'h41;
   localparam logic [7:0] KEY_UP_F   = 8'h46;
   localparam logic [7:0] KEY_LO_A   = 8'h61;
   localparam logic [7:0] KEY_LO_Z   = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'd32;
   localparam logic [7:0] LETTER_OFS = 8'd55;

   localparam logic [7:0] OP_EQ  = 8'h3D;
   localparam logic [7:0] OP_ADD = 8'h2B;
   localparam logic [7:0] OP_SUB = 8'h2D;
   localparam logic [7:0] OP_MUL = 8'h2A;
   localparam logic [7:0] OP_AND = 8'h26;
   localparam logic [7:0] OP_OR  = 8'h7C;
   localparam logic [7:0] OP_XOR = 8'h5E;
   localparam logic [7:0] OP_SHL = 8'h3C;
   localparam logic [7:0] OP_SHR = 8'h3E;
   localparam logic [7:0] OP_DIV = 8'h2F;
   localparam logic [7:0] OP_MOD = 8'h25;

   typedef enum logic [1:0] {
      KC_DIGIT,
      KC_BACK,
      KC_ESC,
      KC_OPER
   } key_class_type;

   typedef enum logic {
      ALU_IDLE,
      ALU_RUN
   } alu_state_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_CALC
   } ctrl_state_type;

   typedef struct packed {
      logic       start;
      logic [7:0] op;
   } alu_req_type;

   function automatic logic [7:0] key_fold(input logic [7:0] k);
      logic [7:0] r;
      r = k;
      if (k >= KEY_LO_A && k <= KEY_LO_Z) begin
         r = k - CASE_DIFF;
      end
      if (r == KEY_CR) begin
         r = OP_EQ;
      end
      return r;
   endfunction

   function automatic key_class_type key_classify(input logic [7:0] k);
      key_class_type c;
      if (k == KEY_BS) begin
         c = KC_BACK;
      end else if (k == KEY_ESCAPE) begin
         c = KC_ESC;
      end else if ((k >= KEY_0 && k <= KEY_9) || (k >= KEY_UP_A && k <= KEY_UP_F)) begin
         c = KC_DIGIT;
      end else begin
         c = KC_OPER;
      end
      return c;
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] k);
      logic [7:0] d;
      if (k <= KEY_9) begin
         d = k - KEY_0;
      end else begin
         d = k - LETTER_OFS;
      end
      return d[3:0];
   endfunction

endpackage

>>> hdl/hkc_alu.sv
`timescale 1ns / 1ps

module hkc_alu
   import hkc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_req_type           req,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH'(DATA_WIDTH);

   alu_state_type state_ff, state_in;
   logic [7:0] op_ff, op_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic carry_ff, carry_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;

   logic sum_bit;
   logic [DATA_WIDTH:0] trial;
   logic q_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      carry_ff  <= carry_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      carry_in  = carry_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      sum_bit   = a_ff[0] ^ b_ff[0] ^ carry_ff;
      trial     = {acc_ff, a_ff[DATA_WIDTH-1]} - {1'b0, b_ff};
      q_bit     = ~trial[DATA_WIDTH];

      unique case (state_ff)
         ALU_IDLE: begin
            if (req.start) begin
               op_in    = req.op;
               a_in     = opa;
               b_in     = opb;
               acc_in   = '0;
               carry_in = 1'b0;
               cnt_in   = CNT_FULL;
               case (req.op)
                  OP_EQ: begin
                     done_in   = 1'b1;
                     result_in = opb;
                  end
                  OP_AND: begin
                     done_in   = 1'b1;
                     result_in = opa & opb;
                  end
                  OP_OR: begin
                     done_in   = 1'b1;
                     result_in = opa | opb;
                  end
                  OP_XOR: begin
                     done_in   = 1'b1;
                     result_in = opa ^ opb;
                  end
                  OP_ADD, OP_MUL: begin
                     state_in = ALU_RUN;
                  end
                  OP_SUB: begin
                     b_in     = ~opb;
                     carry_in = 1'b1;
                     state_in = ALU_RUN;
                  end
                  OP_DIV, OP_MOD: begin
                     if (opb == '0) begin
                        done_in   = 1'b1;
                        result_in = '1;
                     end else begin
                        state_in = ALU_RUN;
                     end
                  end
                  OP_SHL, OP_SHR: begin
                     if (opb >= WIDTH_VAL) begin
                        done_in   = 1'b1;
                        result_in = '0;
                     end else if (opb == '0) begin
                        done_in   = 1'b1;
                        result_in = opa;
                     end else begin
                        cnt_in   = opb[CNT_W-1:0];
                        state_in = ALU_RUN;
                     end
                  end
                  default: begin
                     done_in   = 1'b1;
                     result_in = '0;
                  end
               endcase
            end
         end
         ALU_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  acc_in   = {sum_bit, acc_ff[DATA_WIDTH-1:1]};
                  carry_in = (a_ff[0] & b_ff[0]) | (carry_ff & (a_ff[0] ^ b_ff[0]));
                  a_in     = a_ff >> 1;
                  b_in     = b_ff >> 1;
                  result_in = acc_in;
               end
               OP_MUL: begin
                  acc_in    = acc_ff + (b_ff[0] ? a_ff : '0);
                  a_in      = a_ff << 1;
                  b_in      = b_ff >> 1;
                  result_in = acc_in;
               end
               OP_DIV, OP_MOD: begin
                  if (q_bit) begin
                     acc_in = trial[DATA_WIDTH-1:0];
                  end else begin
                     acc_in = {acc_ff[DATA_WIDTH-2:0], a_ff[DATA_WIDTH-1]};
                  end
                  a_in      = {a_ff[DATA_WIDTH-2:0], q_bit};
                  result_in = (op_ff == OP_DIV) ? a_in : acc_in;
               end
               OP_SHL: begin
                  a_in      = a_ff << 1;
                  result_in = a_in;
               end
               default: begin
                  a_in      = a_ff >> 1;
                  result_in = a_in;
               end
            endcase
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = ALU_IDLE;
            end
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> hdl/hex_key_calculator_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                         Contents
// req       in         req_tvalid/tready/tdata       tdata[7:0] key
// rsp       out        rsp_tvalid/tready/tdata/tuser tdata[31:0] display, tuser[0] beep
//
// Digits, backspace, escape and operator keys with no digit since reset or the last operator
// key get a registered response. Computing keys use the bit-serial unit: '=' and logic ops
// at once; add, subtract, multiply, divide and modulo over DATA_WIDTH bits; shifts b bits.
// One key is handled at a time; req_tready drops while a calculation runs or a response
// waits without rsp_tready. Reset is synchronous and returns entry 0, pending '='.

module hex_key_calculator_unit
   import hkc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] key
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DISP_WIDTH-1:0] rsp_tdata,   // [31:0] display
   output logic [0:0]            rsp_tuser    // [0] beep
);

   ctrl_state_type state_ff, state_in;
   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic [DATA_WIDTH-1:0] first_ff, first_in;
   logic [7:0] pend_ff, pend_in;
   logic newnum_ff, newnum_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_beep_ff, rsp_beep_in;
   logic [DISP_WIDTH-1:0] rsp_disp_ff, rsp_disp_in;

   logic [7:0] key_n;
   key_class_type key_class;
   logic [DATA_WIDTH-1:0] base;
   logic [DISP_WIDTH-1:0] disp_next;
   logic accept;
   alu_req_type alu_req;
   logic alu_done;
   logic [DATA_WIDTH-1:0] alu_result;

   hkc_alu #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (first_ff),
      .opb    (entry_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   generate
      if (DATA_WIDTH >= DISP_WIDTH) begin : g_disp_trunc
         assign disp_next = entry_in[DISP_WIDTH-1:0];
      end else begin : g_disp_ext
         assign disp_next = {{(DISP_WIDTH - DATA_WIDTH){1'b0}}, entry_in};
      end
   endgenerate

   assign key_n      = key_fold(req_tdata);
   assign key_class  = key_classify(key_n);
   assign req_tready = (state_ff == CTRL_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         entry_ff     <= '0;
         first_ff     <= '0;
         pend_ff      <= OP_EQ;
         newnum_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         first_ff     <= first_in;
         pend_ff      <= pend_in;
         newnum_ff    <= newnum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_beep_ff <= rsp_beep_in;
      rsp_disp_ff <= rsp_disp_in;
   end

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      first_in     = first_ff;
      pend_in      = pend_ff;
      newnum_in    = newnum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_beep_in  = rsp_beep_ff;
      rsp_disp_in  = rsp_disp_ff;
      alu_req      = '{start: 1'b0, op: pend_ff};
      base         = newnum_ff ? '0 : entry_ff;

      unique case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               rsp_beep_in  = 1'b0;
               rsp_valid_in = 1'b1;
               unique case (key_class)
                  KC_BACK: begin
                     entry_in = entry_ff >> 4;
                  end
                  KC_ESC: begin
                     entry_in = '0;
                  end
                  KC_DIGIT: begin
                     if (newnum_ff) begin
                        first_in = entry_ff;
                     end
                     newnum_in = 1'b0;
                     if (base[DATA_WIDTH-1:DATA_WIDTH-4] == 4'd0) begin
                        entry_in = {base[DATA_WIDTH-5:0], digit_value(key_n)};
                     end else begin
                        entry_in    = base;
                        rsp_beep_in = 1'b1;
                     end
                  end
                  KC_OPER: begin
                     pend_in   = key_n;
                     newnum_in = 1'b1;
                     if (!newnum_ff) begin
                        alu_req.start = 1'b1;
                        rsp_valid_in  = 1'b0;
                        state_in      = CTRL_CALC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CTRL_CALC: begin
            if (alu_done) begin
               entry_in     = alu_result;
               rsp_beep_in  = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
      rsp_disp_in = (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) ? disp_next : rsp_disp_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_disp_ff;
   assign rsp_tuser  = rsp_beep_ff;

`ifndef SYNTHESIS
   a_calc_no_rsp : assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_CALC |-> !rsp_valid_ff)
      else $error("response pending during calculation");

   a_done_in_calc : assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == CTRL_CALC)
      else $error("arithmetic unit finished outside a calculation");

   a_beep_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beep_ff |-> entry_ff[DATA_WIDTH-1:DATA_WIDTH-4] != 4'd0)
      else $error("beep with room left in entry");

   a_digit_clears_new : assert property (@(posedge clock) disable iff (reset)
      accept && key_class == KC_DIGIT |=> !newnum_ff)
      else $error("digit left new-number flag set");
`endif

endmodule

>>> bench/hex_key_calculator_unit_tb.sv
`timescale 1ns / 1ps

module hex_key_calculator_unit_tb;
   import hkc_pkg::*;

   typedef struct packed {
      logic [DISP_WIDTH-1:0] display;
      logic                  beep;
   } calc_result_type;

   localparam logic [DISP_WIDTH-1:0] ENTRY_LIMIT = {DISP_WIDTH{1'b1}} >> 4;
   localparam int                    OPER_COUNT  = 12;
   localparam logic [7:0] OPER_KEYS [OPER_COUNT] = '{
      OP_EQ, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR,
      OP_XOR, OP_SHL, OP_SHR, OP_DIV, OP_MOD, KEY_CR
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] key
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DISP_WIDTH-1:0] rsp_tdata;   // [31:0] display
   logic [0:0]            rsp_tuser;   // [0] beep

   logic [DISP_WIDTH-1:0] calc_entry;
   logic [DISP_WIDTH-1:0] calc_operand;
   logic [7:0]            calc_pending_op;
   logic                  calc_new_number;

   calc_result_type display_queue[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int hold_off_cycles;
   int error_count;
   int keys_sent;
   int results_seen;
   int beeps_seen;

   hex_key_calculator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("** hex_key_calculator_unit: FAILED **");
      $finish;
   end

   function automatic logic [DISP_WIDTH-1:0] apply_operator(input logic [DISP_WIDTH-1:0] a,
                                                            input logic [7:0] op,
                                                            input logic [DISP_WIDTH-1:0] b);
      logic [DISP_WIDTH-1:0] r;
      case (op)
         OP_EQ:  r = b;
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         OP_AND: r = a & b;
         OP_OR:  r = a | b;
         OP_XOR: r = a ^ b;
         OP_SHL: r = (b >= DISP_WIDTH) ? '0 : (a << b);
         OP_SHR: r = (b >= DISP_WIDTH) ? '0 : (a >> b);
         OP_DIV: r = (b == '0) ? '1 : (a / b);
         OP_MOD: r = (b == '0) ? '1 : (a % b);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic calc_result_type calc_key(input logic [7:0] raw);
      logic [7:0]      k;
      logic [7:0]      nib;
      logic            is_digit;
      calc_result_type res;
      k = raw;
      if (k >= KEY_LO_A && k <= KEY_LO_Z) begin
         k = k - CASE_DIFF;
      end
      if (k == KEY_CR) begin
         k = OP_EQ;
      end
      is_digit = 1'b1;
      nib = '0;
      if (k >= KEY_0 && k <= KEY_9) begin
         nib = k - KEY_0;
      end else if (k >= KEY_UP_A && k <= KEY_UP_F) begin
         nib = k - KEY_UP_A + 8'd10;
      end else begin
         is_digit = 1'b0;
      end
      res.beep = 1'b0;
      if (k == KEY_BS) begin
         calc_entry = calc_entry >> 4;
      end else if (k == KEY_ESCAPE) begin
         calc_entry = '0;
      end else if (is_digit) begin
         if (calc_new_number) begin
            calc_operand = calc_entry;
            calc_entry = '0;
         end
         calc_new_number = 1'b0;
         if (calc_entry <= ENTRY_LIMIT) begin
            calc_entry = {calc_entry[DISP_WIDTH-5:0], nib[3:0]};
         end else begin
            res.beep = 1'b1;
         end
      end else begin
         if (!calc_new_number) begin
            calc_entry = apply_operator(calc_operand, calc_pending_op, calc_entry);
         end
         calc_new_number = 1'b1;
         calc_pending_op = k;
      end
      res.display = calc_entry;
      return res;
   endfunction

   function automatic logic [7:0] random_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return KEY_0 + 8'(v);
      end else if ($urandom_range(0, 1) == 0) begin
         return KEY_UP_A + 8'(v - 10);
      end
      return KEY_LO_A + 8'(v - 10);
   endfunction

   task automatic send_key(input logic [7:0] key);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      display_queue.push_back(calc_key(key));
      keys_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (display_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      calc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (display_queue.size() == 0) begin
            $error("unexpected response transaction: display %h beep %0b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = display_queue.pop_front();
            if (rsp_tdata !== want.display) begin
               $error("display: expected %h, got %h", want.display, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.beep) begin
               $error("beep: expected %0b, got %0b", want.beep, rsp_tuser[0]);
               error_count++;
            end
            if (want.beep) begin
               beeps_seen++;
            end
         end
      end
   end

   task automatic test_directed();
      logic [7:0] keys [36] = '{
         "f", "f", "f", "f", "f", "f", "f", "f", "A", KEY_BS,
         8'h00, "3", OP_DIV, "0", KEY_CR, OP_MOD, "0", OP_SHL, "2", "1",
         OP_SHR, "4", OP_SUB, "9", OP_MUL, "c", OP_AND, "7", OP_OR, "5",
         OP_XOR, "e", OP_ADD, "b", 8'hFF, KEY_ESCAPE
      };
      send_idle_pct = 24;
      rsp_idle_pct  = 59;
      foreach (keys[i]) begin
         send_key(keys[i]);
      end
      wait_for_results();
   endtask

   task automatic test_random(input int snd_pct, input int rcv_pct, input int count);
      int target;
      int ndig;
      int pick;
      send_idle_pct = snd_pct;
      rsp_idle_pct  = rcv_pct;
      target = keys_sent + count;
      while (keys_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
            repeat (ndig) begin
               send_key(random_digit());
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               send_key(KEY_BS);
            end else if (pick < 14) begin
               send_key(KEY_ESCAPE);
            end
            send_key(OPER_KEYS[$urandom_range(0, OPER_COUNT - 1)]);
         end else begin
            send_key(8'($urandom_range(0, 255)));
         end
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      @(posedge clock);
      hold_off_cycles = 200;
      repeat (30) begin
         send_key(random_digit());
         send_key(OPER_KEYS[$urandom_range(0, OPER_COUNT - 1)]);
      end
      wait_for_results();
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      hold_off_cycles = 0;
      error_count     = 0;
      keys_sent       = 0;
      results_seen    = 0;
      beeps_seen      = 0;
      calc_entry      = '0;
      calc_operand    = '0;
      calc_pending_op = OP_EQ;
      calc_new_number = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(24, 59, 600);
      test_random(59, 24, 600);
      test_random(0, 0, 600);
      test_backpressure();

      repeat (40) @(posedge clock);
      if (display_queue.size() != 0) begin
         $error("%0d response transactions never arrived", display_queue.size());
         error_count++;
      end
      $display("Sent %0d keys and checked %0d responses (%0d overflow beeps)",
               keys_sent, results_seen, beeps_seen);
      $display("Covered all operators, edge cases, random idling and a long output stall");
      if (error_count == 0) begin
         $display("** hex_key_calculator_unit: PASSED **");
      end else begin
         $display("** hex_key_calculator_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/hkc_pkg.sv
hdl/hkc_alu.sv
hdl/hex_key_calculator_unit.sv
bench/hex_key_calculator_unit_tb.sv
